### rtl/cicd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cicd_pkg
// Shared types, widths and helpers for the CIC decimator.
// ----------------------------------------------------------------------------
package cicd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PCM_W     = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned LOG2_W    = 5;
  localparam int unsigned GAIN_W    = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_DECIMATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT      = 1'd1;

  localparam logic [LOG2_W-1:0] LOG2_DECIMATION_RST = 5'd6;
  localparam logic [GAIN_W-1:0] GAIN_SHIFT_RST      = 6'd0;

  localparam logic [DATA_W-1:0] PCM_OFFSET = 32'd32768;

  // Per-stage tag that travels with each sample down the integrator chain.
  typedef struct packed {
    logic valid;
    logic dump;
  } stage_ctl_t;

  // Phase counter mask; exponents above the counter width saturate to all ones.
  function automatic logic [CNT_W-1:0] count_mask(input logic [LOG2_W-1:0] log2_dec);
    logic [CNT_W:0] span;
    logic [CNT_W:0] mask;
    span = (CNT_W + 1)'(1) << log2_dec;
    mask = span - (CNT_W + 1)'(1);
    return mask[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/cicd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cicd_sample_if / cicd_pcm_if
// Valid/ready channels for input samples and PCM results.
// ----------------------------------------------------------------------------
interface cicd_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cicd_pcm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_out;

  modport source (output valid, output pcm_out, input ready);
  modport sink   (input valid, input pcm_out, output ready);
endinterface
`default_nettype wire

### rtl/cic_decimator_pdm_to_pcm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cic_decimator_pdm_to_pcm_core
// Pipelined CIC decimator from 32-bit samples to 16-bit PCM.
// ----------------------------------------------------------------------------
// One sample is accepted per cycle while ready is high. Each integrator and
// each comb has its own register stage, followed by the gain/offset result
// register; a completed decimation period passes through them in that order.
// The whole pipeline advances together; it halts, and ready drops,
// only while the result register holds a transaction not yet taken.
// ----------------------------------------------------------------------------
module cic_decimator_pdm_to_pcm_core
  import cicd_pkg::*;
#(
  parameter int unsigned NUM_STAGES = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  cicd_sample_if.sink               in_i,
  cicd_pcm_if.source                out_o
);

  logic [LOG2_W-1:0] log2_dec_q;
  logic [GAIN_W-1:0] gain_q;
  logic [CNT_W-1:0]  phase_q;
  logic [CNT_W-1:0]  phase_d;
  logic              en;
  logic              accept;

  stage_ctl_t        integ_ctl [NUM_STAGES+1];
  logic [DATA_W-1:0] integ_x   [NUM_STAGES+1];
  logic              comb_vld  [NUM_STAGES+1];
  logic [DATA_W-1:0] comb_x    [NUM_STAGES+1];

  logic              res_valid;
  logic [PCM_W-1:0]  res_pcm;

  assign en     = !res_valid || out_o.ready;
  assign accept = in_i.valid && en;
  assign phase_d = (phase_q + CNT_W'(1)) & count_mask(log2_dec_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_dec_q <= LOG2_DECIMATION_RST;
      gain_q     <= GAIN_SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOG2_DECIMATION: log2_dec_q <= cfg_wdata_i[LOG2_W-1:0];
        CFG_GAIN_SHIFT:      gain_q     <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  assign integ_ctl[0].valid = accept;
  assign integ_ctl[0].dump  = (phase_d == '0);
  assign integ_x[0]         = in_i.sample_in;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_integ
    cicd_integ_stage u_integ (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (integ_ctl[s]),
      .x_i    (integ_x[s]),
      .ctl_o  (integ_ctl[s+1]),
      .x_o    (integ_x[s+1])
    );
  end

  assign comb_vld[0] = integ_ctl[NUM_STAGES].valid && integ_ctl[NUM_STAGES].dump;
  assign comb_x[0]   = integ_x[NUM_STAGES];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_comb
    cicd_comb_stage u_comb (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (comb_vld[s]),
      .x_i     (comb_x[s]),
      .valid_o (comb_vld[s+1]),
      .y_o     (comb_x[s+1])
    );
  end

  cicd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (comb_vld[NUM_STAGES]),
    .x_i     (comb_x[NUM_STAGES]),
    .gain_i  (gain_q),
    .valid_o (res_valid),
    .pcm_o   (res_pcm)
  );

  assign in_i.ready    = en;
  assign out_o.valid   = res_valid;
  assign out_o.pcm_out = res_pcm;

endmodule
`default_nettype wire

### rtl/cicd_integ_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cicd_integ_stage
// One registered integrator: accumulates each valid sample modulo 2^32.
// ----------------------------------------------------------------------------
module cicd_integ_stage
  import cicd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire stage_ctl_t        ctl_i,
  input  wire logic [DATA_W-1:0] x_i,
  output stage_ctl_t             ctl_o,
  output logic      [DATA_W-1:0] x_o
);

  stage_ctl_t        ctl_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] acc_d;

  assign acc_d = acc_q + x_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      acc_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
      if (ctl_i.valid) begin
        acc_q <= acc_d;
      end
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = acc_q;

endmodule
`default_nettype wire

### rtl/cicd_comb_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cicd_comb_stage
// One registered comb: differences each decimated sample with the previous one.
// ----------------------------------------------------------------------------
module cicd_comb_stage
  import cicd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DATA_W-1:0] x_i,
  output logic                   valid_o,
  output logic      [DATA_W-1:0] y_o
);

  logic              valid_q;
  logic [DATA_W-1:0] delay_q;
  logic [DATA_W-1:0] y_q;
  logic [DATA_W-1:0] y_d;

  assign y_d = x_i - delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      delay_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        delay_q <= x_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      y_q <= y_d;
    end
  end

  assign valid_o = valid_q;
  assign y_o     = y_q;

endmodule
`default_nettype wire

### rtl/cicd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cicd_out_stage
// Gain shift, offset removal and 16-bit result register.
// ----------------------------------------------------------------------------
module cicd_out_stage
  import cicd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DATA_W-1:0] x_i,
  input  wire logic [GAIN_W-1:0] gain_i,
  output logic                   valid_o,
  output logic      [PCM_W-1:0]  pcm_o
);

  logic              valid_q;
  logic [PCM_W-1:0]  pcm_q;
  logic [GAIN_W-1:0] mag;
  logic [DATA_W-1:0] scaled;
  logic [DATA_W-1:0] biased;

  always_comb begin
    mag = -gain_i;
    if (!gain_i[GAIN_W-1]) begin
      scaled = x_i << gain_i[GAIN_W-2:0];
    end else if (mag[GAIN_W-1]) begin
      scaled = '0;
    end else begin
      scaled = x_i >> mag[GAIN_W-2:0];
    end
    biased = scaled - PCM_OFFSET;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      pcm_q <= biased[PCM_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign pcm_o   = pcm_q;

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CIC decimator core. Samples are pushed through
// the valid/ready input channel, and a bit-accurate predictor of the
// integrator/comb chain tracks the expected PCM transactions. Each output
// transaction is checked in order. Ratio and gain are reprogrammed between
// phases while the core is idle. Random stalls hit both channels, and one
// long output hold backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import cicd_pkg::*;

  localparam int NSTAGES     = 4;
  localparam int SETTLE_CYC  = 2 * NSTAGES + 4;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 500_000;

  class pcm_predictor;
    logic [DATA_W-1:0]        integ    [NSTAGES];
    logic [DATA_W-1:0]        comb_dly [NSTAGES];
    logic [CNT_W-1:0]         phase;
    logic [LOG2_W-1:0]        log2_dec;
    logic signed [GAIN_W-1:0] gain;
    logic [PCM_W-1:0]         pcm_expected [$];
    int                       mismatches;

    function new();
      for (int i = 0; i < NSTAGES; i++) begin
        integ[i]    = '0;
        comb_dly[i] = '0;
      end
      phase      = '0;
      log2_dec   = LOG2_DECIMATION_RST;
      gain       = GAIN_SHIFT_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_LOG2_DECIMATION) begin
        log2_dec = data[LOG2_W-1:0];
      end else if (idx == CFG_GAIN_SHIFT) begin
        gain = data[GAIN_W-1:0];
      end
    endfunction

    function void take_sample(logic [DATA_W-1:0] smp);
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] scaled;
      logic [DATA_W-1:0] span;
      logic [DATA_W-1:0] taps [NSTAGES];
      int                g;
      acc = smp;
      for (int i = 0; i < NSTAGES; i++) begin
        integ[i] = integ[i] + acc;
        acc = integ[i];
      end
      // ratio exponent saturates at the counter width
      if (log2_dec >= CNT_W) begin
        span = '1;
      end else begin
        span = (32'd1 << log2_dec) - 32'd1;
      end
      phase = (phase + 1'b1) & span[CNT_W-1:0];
      if (phase != '0) return;
      x = integ[NSTAGES-1];
      for (int i = 0; i < NSTAGES; i++) begin
        taps[i] = x;
        x = x - comb_dly[i];
      end
      for (int i = 0; i < NSTAGES; i++) comb_dly[i] = taps[i];
      g = int'(gain);
      if (g >= 0) begin
        scaled = x << g;
      end else if (-g >= DATA_W) begin
        scaled = '0;
      end else begin
        scaled = x >> (-g);
      end
      acc = scaled - PCM_OFFSET;
      pcm_expected.push_back(acc[PCM_W-1:0]);
    endfunction

    function void check_pcm(logic [PCM_W-1:0] got);
      logic [PCM_W-1:0] want;
      if (pcm_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected pcm transaction %h", $realtime, got);
        return;
      end
      want = pcm_expected.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: pcm_out mismatch: expected %h (%0d) got %h (%0d)", $realtime,
                   want, $signed(want), got, $signed(got));
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  cicd_sample_if sample_ch ();
  cicd_pcm_if    pcm_ch ();

  pcm_predictor predictor = new();

  bit tx_idle_en;
  bit rx_idle_en;
  int pcm_hold_cycles;
  int cycle_cnt;

  cic_decimator_pdm_to_pcm_core #(
    .NUM_STAGES (NSTAGES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (sample_ch),
    .out_o       (pcm_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pcm_ch.valid && pcm_ch.ready) predictor.check_pcm(pcm_ch.pcm_out);
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // output side: random stalls plus one long hold requested by the stimulus
  initial begin : pcm_sink
    pcm_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (pcm_hold_cycles > 0) begin
        pcm_ch.ready <= 1'b0;
        repeat (pcm_hold_cycles) @(posedge clk_i);
        pcm_hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        pcm_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        pcm_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(input logic [DATA_W-1:0] smp);
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_in <= smp;
    do @(posedge clk_i); while (!sample_ch.ready);
    predictor.take_sample(smp);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // stop sending, wait for every pending PCM transaction, let the pipe empty
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (predictor.pcm_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    predictor.write_reg(idx, data);
  endtask

  task automatic set_ratio(input logic [LOG2_W-1:0] log2_val);
    logic [CFG_W-LOG2_W-1:0] junk;
    junk = (CFG_W-LOG2_W)'($urandom_range(0, 1));
    program_reg(CFG_LOG2_DECIMATION, {junk, log2_val});
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: return DATA_W'($urandom_range(0, 1));
      3:       return '1;
      4:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 6'sd0;
      1:       return 6'sd31;
      2:       return 6'b100000;
      3:       return -6'sd31;
      default: return GAIN_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin : stimulus
    int n_random;
    int n;
    int span;
    int pick;
    int log2_pick;
    bit hold_done;
    rst_ni              = 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_wdata_i         <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.sample_in <= '0;
    tx_idle_en          = 1'b0;
    rx_idle_en          = 1'b0;
    pcm_hold_cycles     = 0;
    n_random            = 0;
    hold_done           = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ratio and gain, two decimation periods
    repeat (128) send_sample(pick_sample());

    // directed corners
    set_ratio(5'd0);
    program_reg(CFG_GAIN_SHIFT, 6'sd0);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    program_reg(CFG_GAIN_SHIFT, 6'sd31);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0000);
    program_reg(CFG_GAIN_SHIFT, 6'b100000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h1234_5678);
    program_reg(CFG_GAIN_SHIFT, -6'sd31);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h8000_0000);
    program_reg(CFG_GAIN_SHIFT, -6'sd1);
    send_sample(32'hA5A5_5A5A);
    // ratio above the counter width, then a smaller one with the count left running
    set_ratio(5'd17);
    repeat (3) send_sample(pick_sample());
    set_ratio(5'd1);
    repeat (3) send_sample(pick_sample());
    set_ratio(5'd16);
    repeat (2) send_sample(pick_sample());
    set_ratio(5'd31);
    repeat (2) send_sample(pick_sample());

    while (n_random < RANDOM_ITEMS) begin
      if (n_random > RANDOM_ITEMS - 300) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      if (!hold_done && n_random >= 300) begin
        // back up the pipeline behind a long output hold
        set_ratio(5'd0);
        program_reg(CFG_GAIN_SHIFT, pick_gain());
        tx_idle_en      = 1'b0;
        pcm_hold_cycles = 200;
        hold_done       = 1'b1;
        n = 80;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          log2_pick = $urandom_range(0, 4);
        end else if (pick < 17) begin
          log2_pick = $urandom_range(5, 8);
        end else if (pick == 17) begin
          log2_pick = 16;
        end else begin
          log2_pick = $urandom_range(17, 31);
        end
        span = (log2_pick <= 8) ? (3 << log2_pick) + 8 : 30;
        if (span > 600) span = 600;
        n = $urandom_range(1, span);
        set_ratio(log2_pick[LOG2_W-1:0]);
        if ($urandom_range(0, 1) != 0) program_reg(CFG_GAIN_SHIFT, pick_gain());
      end
      if (n > RANDOM_ITEMS - n_random) n = RANDOM_ITEMS - n_random;
      repeat (n) begin
        send_sample(pick_sample());
        n_random++;
      end
    end

    settle();
    if (predictor.mismatches == 0 && predictor.pcm_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cicd_pkg.sv
rtl/cicd_if.sv
rtl/cicd_integ_stage.sv
rtl/cicd_comb_stage.sv
rtl/cicd_out_stage.sv
rtl/cic_decimator_pdm_to_pcm_core.sv
tb/tb_top.sv
